// ===== design/h2r_pkg.sv =====
// shared types, widths and constants of the hsv to rgb converter
`timescale 1ns / 1ps

package h2r_pkg;

  // channel and intermediate widths
  localparam int CH_W  = 8;   // one colour channel
  localparam int R_W   = 7;   // remainder within a sector, 0..84
  localparam int MUL_W = 15;  // saturation times sector fraction, up to 21675
  localparam int NP_W  = 16;  // v * (255 - s)
  localparam int NQ_W  = 23;  // v * (21675 - s * r)

  // hue circle geometry
  localparam int unsigned SECTOR_DEN = 85;
  localparam int unsigned SECTOR_CNT = 6;
  localparam int unsigned FULL_SCALE = 255;
  localparam int unsigned FRAC_DEN   = FULL_SCALE * SECTOR_DEN;

  // hue sectors, named by the colours at their ends
  typedef enum logic [2:0] {
    SEC_RY,
    SEC_YG,
    SEC_GC,
    SEC_CB,
    SEC_BM,
    SEC_MR
  } h2r_sector_t;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } h2r_stage_en_t;

  // payload after the fraction products
  typedef struct packed {
    h2r_sector_t            sector;
    logic [CH_W-1:0]        v;
    logic [CH_W-1:0]        ps;
    logic [MUL_W-1:0]       mq;
    logic [MUL_W-1:0]       mt;
  } h2r_frac_t;

  // payload after the numerator products
  typedef struct packed {
    h2r_sector_t            sector;
    logic [CH_W-1:0]        v;
    logic [NP_W-1:0]        np;
    logic [NQ_W-1:0]        nq;
    logic [NQ_W-1:0]        nt;
  } h2r_numer_t;

  // sideband carried next to the dividers
  typedef struct packed {
    h2r_sector_t            sector;
    logic [CH_W-1:0]        v;
  } h2r_side_t;

endpackage

// ===== design/h2r_hsv_if.sv =====
// input channel: hue, saturation and brightness with valid and ready
`timescale 1ns / 1ps

interface h2r_hsv_if;
  logic                     valid;
  logic                     ready;
  logic [h2r_pkg::CH_W-1:0] hue;
  logic [h2r_pkg::CH_W-1:0] saturation;
  logic [h2r_pkg::CH_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

// ===== design/h2r_rgb_if.sv =====
// result channel: red, green and blue with valid and ready
`timescale 1ns / 1ps

interface h2r_rgb_if;
  logic                     valid;
  logic                     ready;
  logic [h2r_pkg::CH_W-1:0] red;
  logic [h2r_pkg::CH_W-1:0] green;
  logic [h2r_pkg::CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input red, input green, input blue,
                  output ready);
endinterface

// ===== design/h2r_hue_frac.sv =====
// stages one and two: hue sector split and saturation fraction products
`timescale 1ns / 1ps

module h2r_hue_frac (
  input  logic                      clk,
  input  h2r_pkg::h2r_stage_en_t    en,
  input  logic [h2r_pkg::CH_W-1:0]  hue,
  input  logic [h2r_pkg::CH_W-1:0]  sat,
  input  logic [h2r_pkg::CH_W-1:0]  bri,
  output h2r_pkg::h2r_frac_t        frac
);
  import h2r_pkg::*;

  logic [CH_W:0]    twice;
  logic [CH_W:0]    base;
  h2r_sector_t      sec_nxt;
  logic [R_W-1:0]   rem_nxt;

  h2r_sector_t      sec_r;
  logic [R_W-1:0]   rem_r;
  logic [CH_W-1:0]  sat_r;
  logic [CH_W-1:0]  bri_r;
  h2r_frac_t        frac_nxt;
  h2r_frac_t        frac_r;

  // sector = floor(2h / 85), the top boundary wraps to sector zero
  always_comb begin
    twice   = {hue, 1'b0};
    sec_nxt = SEC_RY;
    base    = '0;
    for (int k = 1; k < SECTOR_CNT; k++) begin
      if (twice >= (CH_W+1)'(k * SECTOR_DEN)) begin
        sec_nxt = h2r_sector_t'(3'(k));
        base    = (CH_W+1)'(k * SECTOR_DEN);
      end
    end
    if (twice >= (CH_W+1)'(SECTOR_CNT * SECTOR_DEN)) begin
      sec_nxt = SEC_RY;
      base    = twice;
    end
    rem_nxt = R_W'(twice - base);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      sec_r <= sec_nxt;
      rem_r <= rem_nxt;
      sat_r <= sat;
      bri_r <= bri;
    end
  end

  always_comb begin
    frac_nxt.sector = sec_r;
    frac_nxt.v      = bri_r;
    frac_nxt.ps     = CH_W'(FULL_SCALE) - sat_r;
    frac_nxt.mq     = MUL_W'(sat_r) * MUL_W'(rem_r);
    frac_nxt.mt     = MUL_W'(sat_r) * MUL_W'(R_W'(SECTOR_DEN) - rem_r);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      frac_r <= frac_nxt;
    end
  end

  assign frac = frac_r;

endmodule

// ===== design/h2r_numer.sv =====
// stage three: brightness times the p, q and t factors
`timescale 1ns / 1ps

module h2r_numer (
  input  logic                      clk,
  input  h2r_pkg::h2r_stage_en_t    en,
  input  h2r_pkg::h2r_frac_t        frac,
  output h2r_pkg::h2r_numer_t       numer
);
  import h2r_pkg::*;

  h2r_numer_t numer_nxt;
  h2r_numer_t numer_r;

  always_comb begin
    numer_nxt.sector = frac.sector;
    numer_nxt.v      = frac.v;
    numer_nxt.np     = NP_W'(frac.v) * NP_W'(frac.ps);
    numer_nxt.nq     = NQ_W'(frac.v) * NQ_W'(MUL_W'(FRAC_DEN) - frac.mq);
    numer_nxt.nt     = NQ_W'(frac.v) * NQ_W'(MUL_W'(FRAC_DEN) - frac.mt);
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      numer_r <= numer_nxt;
    end
  end

  assign numer = numer_r;

endmodule

// ===== design/h2r_round_div.sv =====
// stages four to six: divide by a constant, rounding half up
`timescale 1ns / 1ps

module h2r_round_div #(
  parameter int          NumW = h2r_pkg::NQ_W,
  parameter int unsigned Den  = h2r_pkg::FRAC_DEN
) (
  input  logic                      clk,
  input  h2r_pkg::h2r_stage_en_t    en,
  input  logic [NumW-1:0]           num,
  output logic [h2r_pkg::CH_W-1:0]  quo
);
  import h2r_pkg::*;

  // x = 2n + d, quotient = floor(x / 2d); estimate by reciprocal, then one fix-up
  localparam int                XW    = NumW + 1;
  localparam longint unsigned   DEN2  = 2 * Den;
  localparam longint unsigned   RECIP = (64'd1 << XW) / DEN2;
  localparam int                MW    = $clog2(RECIP + 1);
  localparam int                PW    = XW + MW;

  logic [XW-1:0]    x_r;
  logic [XW-1:0]    x2_r;
  logic [PW-1:0]    prod;
  logic [CH_W-1:0]  est_r;
  logic [XW-1:0]    back;
  logic [XW-1:0]    rem;
  logic [CH_W-1:0]  quo_r;

  always_ff @(posedge clk) begin
    if (en.s4) begin
      x_r <= {num, 1'b0} + XW'(Den);
    end
  end

  // estimate is the true quotient or one below
  assign prod = PW'(x_r) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (en.s5) begin
      est_r <= prod[XW +: CH_W];
      x2_r  <= x_r;
    end
  end

  assign back = XW'(est_r) * XW'(DEN2);
  assign rem  = x2_r - back;

  always_ff @(posedge clk) begin
    if (en.s6) begin
      quo_r <= (rem >= XW'(DEN2)) ? est_r + CH_W'(1) : est_r;
    end
  end

  assign quo = quo_r;

endmodule

// ===== design/hsv_to_rgb_8bit_top.sv =====
// hsv to rgb converter, 8 bits per channel, seven-stage pipeline
// an accepted item shows on out_rgb once it has been loaded into stage seven, the output register
// throughput: one item per clock if out_rgb ready; a stage holds one item, refills as it drains
// a stall on out_rgb backs up stage by stage, so bubbles are squeezed out
// reset (synchronous, active low) clears only the stage valid bits
`timescale 1ns / 1ps

module hsv_to_rgb_8bit_top (
  input  logic        clk,
  input  logic        rst_n,
  h2r_hsv_if.sink     in_hsv,
  h2r_rgb_if.source   out_rgb
);
  import h2r_pkg::*;

  // stage map
  //   1  sector and in-sector remainder from hue
  //   2  s * r, s * (85 - r), 255 - s
  //   3  v times the three factors
  //   4  2n + d for each divider
  //   5  reciprocal estimate of the quotient
  //   6  one-step correction of the estimate
  //   7  sector routing into the output register
  // zero saturation needs no special path: p, q and t all come out equal to v

  localparam int STAGES = 7;

  logic [STAGES:1]  vld_r;
  logic [STAGES:1]  vld_nxt;
  logic [STAGES:1]  en_vec;
  h2r_stage_en_t    en;

  h2r_frac_t        frac;
  h2r_numer_t       numer;
  logic [CH_W-1:0]  p_quo;
  logic [CH_W-1:0]  q_quo;
  logic [CH_W-1:0]  t_quo;

  h2r_side_t        side_r [3];

  logic [CH_W-1:0]  red_nxt;
  logic [CH_W-1:0]  green_nxt;
  logic [CH_W-1:0]  blue_nxt;
  logic [CH_W-1:0]  red_r;
  logic [CH_W-1:0]  green_r;
  logic [CH_W-1:0]  blue_r;

  // a stage loads when it is empty or the stage after it loads too
  always_comb begin
    en_vec[STAGES] = !vld_r[STAGES] || out_rgb.ready;
    for (int i = STAGES - 1; i >= 1; i--) begin
      en_vec[i] = !vld_r[i] || en_vec[i+1];
    end
  end

  always_comb begin
    en.s1 = en_vec[1];
    en.s2 = en_vec[2];
    en.s3 = en_vec[3];
    en.s4 = en_vec[4];
    en.s5 = en_vec[5];
    en.s6 = en_vec[6];
    en.s7 = en_vec[7];
  end

  // valid bits move with the data, held where the stage is stalled
  always_comb begin
    vld_nxt[1] = en_vec[1] ? in_hsv.valid : vld_r[1];
    for (int i = 2; i <= STAGES; i++) begin
      vld_nxt[i] = en_vec[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_hsv.ready = en_vec[1];

  // stages one and two
  h2r_hue_frac u_hue_frac (
    .clk  (clk),
    .en   (en),
    .hue  (in_hsv.hue),
    .sat  (in_hsv.saturation),
    .bri  (in_hsv.brightness),
    .frac (frac)
  );

  // stage three
  h2r_numer u_numer (
    .clk   (clk),
    .en    (en),
    .frac  (frac),
    .numer (numer)
  );

  // stages four to six: p over 255, q and t over 21675
  h2r_round_div #(
    .NumW (NP_W),
    .Den  (FULL_SCALE)
  ) u_div_p (
    .clk (clk),
    .en  (en),
    .num (numer.np),
    .quo (p_quo)
  );

  h2r_round_div #(
    .NumW (NQ_W),
    .Den  (FRAC_DEN)
  ) u_div_q (
    .clk (clk),
    .en  (en),
    .num (numer.nq),
    .quo (q_quo)
  );

  h2r_round_div #(
    .NumW (NQ_W),
    .Den  (FRAC_DEN)
  ) u_div_t (
    .clk (clk),
    .en  (en),
    .num (numer.nt),
    .quo (t_quo)
  );

  // sector and brightness ride alongside the dividers
  always_ff @(posedge clk) begin
    if (en.s4) begin
      side_r[0].sector <= numer.sector;
      side_r[0].v      <= numer.v;
    end
    if (en.s5) begin
      side_r[1] <= side_r[0];
    end
    if (en.s6) begin
      side_r[2] <= side_r[1];
    end
  end

  // route v, p, q, t to the channels by sector
  always_comb begin
    unique case (side_r[2].sector)
      SEC_RY: begin
        red_nxt   = side_r[2].v;
        green_nxt = t_quo;
        blue_nxt  = p_quo;
      end
      SEC_YG: begin
        red_nxt   = q_quo;
        green_nxt = side_r[2].v;
        blue_nxt  = p_quo;
      end
      SEC_GC: begin
        red_nxt   = p_quo;
        green_nxt = side_r[2].v;
        blue_nxt  = t_quo;
      end
      SEC_CB: begin
        red_nxt   = p_quo;
        green_nxt = q_quo;
        blue_nxt  = side_r[2].v;
      end
      SEC_BM: begin
        red_nxt   = t_quo;
        green_nxt = p_quo;
        blue_nxt  = side_r[2].v;
      end
      default: begin
        red_nxt   = side_r[2].v;
        green_nxt = p_quo;
        blue_nxt  = q_quo;
      end
    endcase
  end

  // output register, stage seven
  always_ff @(posedge clk) begin
    if (en.s7) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_rgb.valid = vld_r[STAGES];
  assign out_rgb.red   = red_r;
  assign out_rgb.green = green_r;
  assign out_rgb.blue  = blue_r;

endmodule
